// ===== hdl/wsfu_pkg.sv =====
// Shared types and constants for the WebSocket frame unmasker.
// Used by the channel interfaces, the frame parser, the result queue and the top level.
`default_nettype none

package wsfu_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned LenW      = 64;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned MaxRes    = 3;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);
  localparam int unsigned ResCntW   = $clog2(MaxRes + 1);

  // parser phases; codes 6 and 7 behave as PhHdr0
  localparam logic [2:0] PhHdr0    = 3'd0;
  localparam logic [2:0] PhHdr1    = 3'd1;
  localparam logic [2:0] PhExtLen  = 3'd2;
  localparam logic [2:0] PhMask    = 3'd3;
  localparam logic [2:0] PhPayload = 3'd4;
  localparam logic [2:0] PhError   = 3'd5;

  localparam logic [3:0] OpcClose = 4'd8;
  localparam logic [3:0] OpcPing  = 4'd9;

  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;
  localparam logic [3:0] ExtBytes16 = 4'd2;
  localparam logic [3:0] ExtBytes64 = 4'd8;

  localparam logic [CfgIdxW-1:0] CfgMarkerPing  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMarkerClose = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMarkerStd   = 2'd2;

  localparam logic [ByteW-1:0] RstMarkerPing  = 8'd1;
  localparam logic [ByteW-1:0] RstMarkerClose = 8'd2;
  localparam logic [ByteW-1:0] RstMarkerStd   = 8'd0;

  typedef enum logic [1:0] {
    KindMarker  = 2'd0,
    KindPayload = 2'd1,
    KindTerm    = 2'd2,
    KindStatus  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StUnmasked  = 2'd1,
    StTruncated = 2'd2
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    kind_e            out_kind;
    status_e          status;
    logic             last_of_run;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/wsfu_ifs.sv =====
// Valid/ready channel interfaces: message bytes in, result words out, register writes.
// Depends on wsfu_pkg.
`default_nettype none

interface wsfu_in_if import wsfu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             end_of_message;

  modport source (output valid, output in_byte, output end_of_message, input ready);
  modport sink (input valid, input in_byte, input end_of_message, output ready);
endinterface

interface wsfu_out_if import wsfu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  kind_e            out_kind;
  status_e          status;
  logic             last_of_run;

  modport source (output valid, output out_byte, output out_kind, output status,
                  output last_of_run, input ready);
  modport sink (input valid, input out_byte, input out_kind, input status,
                input last_of_run, output ready);
endinterface

interface wsfu_cfg_if import wsfu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ByteW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/wsfu_parser.sv =====
// Frame parser: header, extended length, mask key, payload unmasking, one byte per fire.
// Produces up to three result words per byte. Depends on wsfu_pkg.
`default_nettype none

module wsfu_parser import wsfu_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               fire_i,
  input  wire logic [ByteW-1:0]   byte_i,
  input  wire logic               eom_i,
  input  wire logic [ByteW-1:0]   marker_ping_i,
  input  wire logic [ByteW-1:0]   marker_close_i,
  input  wire logic [ByteW-1:0]   marker_std_i,
  output      logic [ResCntW-1:0] res_cnt_o,
  output      res_t               res_o [MaxRes]
);

  logic [2:0]       phase_q, phase_d;
  logic [3:0]       opc_q, opc_d;
  logic [LenW-1:0]  rem_q, rem_d;
  logic [3:0]       lbl_q, lbl_d;
  logic [1:0]       pos_q, pos_d;
  status_e          err_q, err_d;
  logic [ByteW-1:0] key_q [4];
  logic             key_we;
  logic [ByteW-1:0] marker;
  logic [ResCntW-1:0] n;
  res_t             res [MaxRes];

  always_comb begin
    if (opc_q == OpcPing) begin
      marker = marker_ping_i;
    end else if (opc_q == OpcClose) begin
      marker = marker_close_i;
    end else begin
      marker = marker_std_i;
    end
  end

  always_comb begin
    phase_d = phase_q;
    opc_d   = opc_q;
    rem_d   = rem_q;
    lbl_d   = lbl_q;
    pos_d   = pos_q;
    err_d   = err_q;
    key_we  = 1'b0;
    n       = '0;
    for (int i = 0; i < MaxRes; i++) begin
      res[i] = '0;
    end

    case (phase_q)
      PhHdr1: begin
        if (!byte_i[7]) begin
          err_d   = StUnmasked;
          phase_d = PhError;
        end else begin
          pos_d = '0;
          if (byte_i[6:0] == Len16Code || byte_i[6:0] == Len64Code) begin
            lbl_d   = (byte_i[6:0] == Len16Code) ? ExtBytes16 : ExtBytes64;
            rem_d   = '0;
            phase_d = PhExtLen;
          end else begin
            rem_d   = LenW'(byte_i[6:0]);
            phase_d = PhMask;
          end
        end
      end
      PhExtLen: begin
        // big-endian: shift in one byte at the bottom
        rem_d = {rem_q[LenW-ByteW-1:0], byte_i};
        lbl_d = lbl_q - 4'd1;
        if (lbl_d == '0) begin
          pos_d   = '0;
          phase_d = PhMask;
        end
      end
      PhMask: begin
        key_we = 1'b1;
        pos_d  = pos_q + 2'd1;
        if (pos_d == '0) begin
          res[n].out_byte = marker;
          res[n].out_kind = KindMarker;
          n = n + 1'b1;
          if (rem_q == '0) begin
            res[n].out_kind = KindTerm;
            n = n + 1'b1;
            phase_d = PhHdr0;
          end else begin
            phase_d = PhPayload;
          end
        end
      end
      PhPayload: begin
        if (rem_q != '0) begin
          res[n].out_byte = byte_i ^ key_q[pos_q];
          res[n].out_kind = KindPayload;
          n = n + 1'b1;
          pos_d = pos_q + 2'd1;
          rem_d = rem_q - LenW'(1);
        end
        if (rem_d == '0) begin
          res[n].out_kind = KindTerm;
          n = n + 1'b1;
          phase_d = PhHdr0;
        end
      end
      PhError: begin
        // swallow bytes until the end of the message
      end
      default: begin
        // a lone trailing header byte is dropped
        if (!eom_i) begin
          opc_d   = byte_i[3:0];
          phase_d = PhHdr1;
        end
      end
    endcase

    if (eom_i) begin
      res[n].out_kind = KindStatus;
      if (err_d != StOk) begin
        res[n].status = err_d;
      end else if (phase_d == PhHdr0 || phase_d > PhError) begin
        res[n].status = StOk;
      end else begin
        res[n].status = StTruncated;
      end
      n = n + 1'b1;
      phase_d = PhHdr0;
      opc_d   = '0;
      rem_d   = '0;
      lbl_d   = '0;
      pos_d   = '0;
      err_d   = StOk;
    end

    if (n != '0) begin
      res[n - 1'b1].last_of_run = 1'b1;
    end
  end

  assign res_cnt_o = n;
  assign res_o     = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHdr0;
      opc_q   <= '0;
      rem_q   <= '0;
      lbl_q   <= '0;
      pos_q   <= '0;
      err_q   <= StOk;
    end else if (fire_i) begin
      phase_q <= phase_d;
      opc_q   <= opc_d;
      rem_q   <= rem_d;
      lbl_q   <= lbl_d;
      pos_q   <= pos_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && key_we) begin
      key_q[pos_q] <= byte_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/wsfu_res_fifo.sv =====
// Result queue: takes up to three result words per cycle, hands out one per cycle.
// Depends on wsfu_pkg.
`default_nettype none

module wsfu_res_fifo import wsfu_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic [ResCntW-1:0] push_cnt_i,
  input  wire res_t               push_data_i [MaxRes],
  input  wire logic               pop_i,
  output      logic               room_o,
  output      logic               valid_o,
  output      res_t               data_o
);

  res_t            mem [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [ResCntW-1:0] push_amt;

  assign push_amt = push_i ? push_cnt_i : '0;
  assign valid_o  = (cnt_q != '0);
  assign data_o   = mem[rd_ptr_q];
  // room for a full run of results, from the registered count only
  assign room_o   = cnt_q <= CntW'(FifoDepth - MaxRes);

  assign wr_ptr_d = wr_ptr_q + PtrW'(push_amt);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop_i);
  assign cnt_d    = cnt_q + CntW'(push_amt) - CntW'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxRes; k++) begin
      if (ResCntW'(k) < push_amt) begin
        mem[wr_ptr_q + PtrW'(k)] <= push_data_i[k];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/websocket_frame_unmasker.sv =====
// WebSocket frame unmasker top level: input byte register, frame parser, result queue.
// A byte's first result word reaches the output through the input byte register and the
// result queue. Throughput: one byte per cycle while results drain one word per cycle; a
// byte fires only while the four-entry result queue holds at most one word, so a byte that
// yields two or three words (marker, terminator, status) stalls input until the queue drains.
// Reset (rst_ni, async low): parser idle, queue empty, markers back to 1, 2 and 0.
`default_nettype none

module websocket_frame_unmasker import wsfu_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  wsfu_in_if.sink       in_i,
  wsfu_out_if.source    out_o,
  wsfu_cfg_if.sink      cfg_i
);

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             eom_q;
  logic             in_acc;
  logic             fire;
  logic             room;
  logic             pop;
  logic             res_valid;
  res_t             res_head;
  logic [ResCntW-1:0] res_cnt;
  res_t             res_run [MaxRes];

  logic [ByteW-1:0] marker_ping_q, marker_close_q, marker_std_q;

  // configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_ping_q  <= RstMarkerPing;
      marker_close_q <= RstMarkerClose;
      marker_std_q   <= RstMarkerStd;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgMarkerPing:  marker_ping_q  <= cfg_i.data;
        CfgMarkerClose: marker_close_q <= cfg_i.data;
        CfgMarkerStd:   marker_std_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // input byte register
  assign fire       = in_valid_q && room;
  assign in_i.ready = !in_valid_q || fire;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_acc) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= in_i.in_byte;
      eom_q     <= in_i.end_of_message;
    end
  end

  wsfu_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .byte_i         (in_byte_q),
    .eom_i          (eom_q),
    .marker_ping_i  (marker_ping_q),
    .marker_close_i (marker_close_q),
    .marker_std_i   (marker_std_q),
    .res_cnt_o      (res_cnt),
    .res_o          (res_run)
  );

  assign pop = res_valid && out_o.ready;

  wsfu_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .push_cnt_i  (res_cnt),
    .push_data_i (res_run),
    .pop_i       (pop),
    .room_o      (room),
    .valid_o     (res_valid),
    .data_o      (res_head)
  );

  assign out_o.valid       = res_valid;
  assign out_o.out_byte    = res_head.out_byte;
  assign out_o.out_kind    = res_head.out_kind;
  assign out_o.status      = res_head.status;
  assign out_o.last_of_run = res_head.last_of_run;

endmodule

`default_nettype wire

// ===== bench/wsfu_frame_checker.sv =====
// Scoreboard for the WebSocket frame unmasker: decodes each accepted input byte into the
// result words it must produce, and compares every accepted output word in order.
// Depends on wsfu_pkg and the channel interfaces in wsfu_ifs.
module wsfu_frame_checker import wsfu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  wsfu_in_if   in_ch,
  wsfu_out_if  out_ch,
  wsfu_cfg_if  cfg_ch,
  output int   mismatches_o,
  output int   words_due_o,
  output int   bytes_seen_o,
  output int   words_seen_o,
  output int   writes_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [ByteW-1:0] marker_ping;
  logic [ByteW-1:0] marker_close;
  logic [ByteW-1:0] marker_std;

  logic [2:0]       parse_phase;
  logic [3:0]       frame_opc;
  logic [LenW-1:0]  bytes_left;
  logic [3:0]       len_bytes_left;
  logic [ByteW-1:0] mask_key [4];
  logic [1:0]       key_pos;
  status_e          msg_error;

  res_t words_due [$];
  res_t want;
  int   due_count   = 0;
  int   mismatches  = 0;
  int   bytes_seen  = 0;
  int   words_seen  = 0;
  int   writes_seen = 0;

  assign mismatches_o  = mismatches;
  assign words_due_o   = due_count;
  assign bytes_seen_o  = bytes_seen;
  assign words_seen_o  = words_seen;
  assign writes_seen_o = writes_seen;

  function automatic res_t make_word(logic [ByteW-1:0] b, kind_e k, status_e s);
    res_t w;
    w.out_byte    = b;
    w.out_kind    = k;
    w.status      = s;
    w.last_of_run = 1'b0;
    return w;
  endfunction

  task automatic report(string what, logic [ByteW-1:0] got, logic [ByteW-1:0] wanted);
    if (mismatches < 30) begin
      $display("[%0t] result word %0d: %s is %0h, should be %0h",
               $time, words_seen, what, got, wanted);
    end
    mismatches++;
  endtask

  task automatic clear_frame();
    parse_phase    = PhHdr0;
    frame_opc      = 4'd0;
    bytes_left     = '0;
    len_bytes_left = 4'd0;
    key_pos        = 2'd0;
  endtask

  // Push the words that one message byte yields; the last of them carries last_of_run.
  task automatic decode_frame_byte(input logic [ByteW-1:0] b, input logic eom);
    int               first;
    logic [ByteW-1:0] marker;
    status_e          st;
    first = words_due.size();
    case (parse_phase)
      PhHdr1: begin
        if (!b[7]) begin
          msg_error   = StUnmasked;
          parse_phase = PhError;
        end else begin
          key_pos = 2'd0;
          if (b[6:0] == Len16Code || b[6:0] == Len64Code) begin
            len_bytes_left = (b[6:0] == Len16Code) ? ExtBytes16 : ExtBytes64;
            bytes_left     = '0;
            parse_phase    = PhExtLen;
          end else begin
            bytes_left  = LenW'(b[6:0]);
            parse_phase = PhMask;
          end
        end
      end
      PhExtLen: begin
        bytes_left     = {bytes_left[LenW-9:0], b};
        len_bytes_left = len_bytes_left - 4'd1;
        if (len_bytes_left == 4'd0) begin
          key_pos     = 2'd0;
          parse_phase = PhMask;
        end
      end
      PhMask: begin
        mask_key[key_pos] = b;
        key_pos           = key_pos + 2'd1;
        if (key_pos == 2'd0) begin
          marker = (frame_opc == OpcPing)  ? marker_ping  :
                   (frame_opc == OpcClose) ? marker_close : marker_std;
          words_due.push_back(make_word(marker, KindMarker, StOk));
          if (bytes_left == '0) begin
            words_due.push_back(make_word(8'h00, KindTerm, StOk));
            parse_phase = PhHdr0;
          end else begin
            parse_phase = PhPayload;
          end
        end
      end
      PhPayload: begin
        if (bytes_left != '0) begin
          words_due.push_back(make_word(b ^ mask_key[key_pos], KindPayload, StOk));
          key_pos    = key_pos + 2'd1;
          bytes_left = bytes_left - 1'b1;
        end
        if (bytes_left == '0) begin
          words_due.push_back(make_word(8'h00, KindTerm, StOk));
          parse_phase = PhHdr0;
        end
      end
      PhError: ;
      default: begin
        // a header byte that ends the message is dropped
        if (!eom) begin
          frame_opc   = b[3:0];
          parse_phase = PhHdr1;
        end
      end
    endcase
    if (eom) begin
      if (msg_error != StOk) st = msg_error;
      else if (parse_phase == PhHdr0 || parse_phase > PhError) st = StOk;
      else st = StTruncated;
      words_due.push_back(make_word(8'h00, KindStatus, st));
      clear_frame();
      msg_error = StOk;
    end
    if (words_due.size() > first) words_due[words_due.size() - 1].last_of_run = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_ping  = RstMarkerPing;
      marker_close = RstMarkerClose;
      marker_std   = RstMarkerStd;
      clear_frame();
      foreach (mask_key[i]) mask_key[i] = 8'h00;
      msg_error = StOk;
      words_due.delete();
      due_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        words_seen++;
        if (words_due.size() == 0) begin
          report("unexpected word, out_byte", out_ch.out_byte, 8'h00);
        end else begin
          want = words_due.pop_front();
          if (out_ch.out_byte !== want.out_byte)
            report("out_byte", out_ch.out_byte, want.out_byte);
          if (out_ch.out_kind !== want.out_kind)
            report("out_kind", 8'(out_ch.out_kind), 8'(want.out_kind));
          if (out_ch.status !== want.status)
            report("status", 8'(out_ch.status), 8'(want.status));
          if (out_ch.last_of_run !== want.last_of_run)
            report("last_of_run", 8'(out_ch.last_of_run), 8'(want.last_of_run));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        writes_seen++;
        case (cfg_ch.index)
          CfgMarkerPing:  marker_ping  = cfg_ch.data;
          CfgMarkerClose: marker_close = cfg_ch.data;
          CfgMarkerStd:   marker_std   = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        bytes_seen++;
        decode_frame_byte(in_ch.in_byte, in_ch.end_of_message);
      end
      due_count = words_due.size();
    end
  end

endmodule

// ===== bench/tb_websocket_frame_unmasker.sv =====
// Top of the frame unmasker bench: clock, reset, message stimulus, register writes and
// output back-pressure; checking is done by wsfu_frame_checker.
// Depends on wsfu_pkg, wsfu_ifs, websocket_frame_unmasker and wsfu_frame_checker.
module tb_websocket_frame_unmasker;
  import wsfu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam int HoldCycles = 150;
  localparam int QuietLimit = 2000;
  localparam int SettleCycles = 8;

  typedef enum int {FormShort, FormMid, FormLong} len_form_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  wsfu_in_if  in_ch ();
  wsfu_out_if out_ch ();
  wsfu_cfg_if cfg_ch ();

  int mismatches;
  int words_due;
  int bytes_seen;
  int words_seen;
  int writes_seen;

  int send_idle_pct = 34;
  int recv_idle_pct = 78;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int bytes_sent = 0;
  logic [ByteW-1:0] msg_q [$];

  websocket_frame_unmasker uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  wsfu_frame_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .mismatches_o  (mismatches),
    .words_due_o   (words_due),
    .bytes_seen_o  (bytes_seen),
    .words_seen_o  (words_seen),
    .writes_seen_o (writes_seen)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Output back-pressure; a toggle of hold_req starts one long hold-off.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("[%0t] no word moved for %0d cycles", $time, QuietLimit);
      $display("websocket_frame_unmasker: mismatch");
      $finish;
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b, input logic eom);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.in_byte        <= b;
    in_ch.end_of_message <= eom;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_q.size(); i++) send_byte(msg_q[i], i == msg_q.size() - 1);
  endtask

  // Stop offering, wait for every expected word, then let swallowed bytes settle.
  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (words_due != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Append one frame; a long frame gets a random length far beyond its payload.
  task automatic append_frame(input int plen, input bit masked, input bit long_len);
    logic [63:0] len_field;
    len_form_e   form;
    int          pick;
    logic [3:0]  opc;
    pick = $urandom_range(2);
    opc = (pick == 0) ? OpcPing : (pick == 1) ? OpcClose : 4'($urandom_range(15));
    msg_q.push_back({4'($urandom_range(15)), opc});
    len_field = 64'(plen);
    if (long_len) begin
      form = FormLong;
      len_field = {32'($urandom()), 32'($urandom())} | (64'd1 << 40);
    end else if ($urandom_range(9) < 7) begin
      form = FormShort;
    end else begin
      form = ($urandom_range(3) == 0) ? FormLong : FormMid;
    end
    case (form)
      FormShort: msg_q.push_back({masked, 7'(plen)});
      FormMid: begin
        msg_q.push_back({masked, Len16Code});
        msg_q.push_back(len_field[15:8]);
        msg_q.push_back(len_field[7:0]);
      end
      default: begin
        msg_q.push_back({masked, Len64Code});
        for (int i = 7; i >= 0; i--) msg_q.push_back(len_field[8*i +: 8]);
      end
    endcase
    repeat (4 + plen) msg_q.push_back(8'($urandom()));
  endtask

  task automatic build_message();
    int pick;
    int nfr;
    int bad;
    int plen;
    int keep;
    msg_q.delete();
    pick = $urandom_range(99);
    nfr = $urandom_range(3, 1);
    if (pick < 88) begin
      bad = (pick >= 78) ? int'($urandom_range(nfr - 1)) : -1;
      for (int f = 0; f < nfr; f++) begin
        plen = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(12, 1));
        append_frame(plen, f != bad, 1'b0);
      end
      if (pick >= 64 && pick < 78) begin
        // cut the message short anywhere
        keep = $urandom_range(msg_q.size() - 2);
        msg_q = msg_q[0:keep];
      end else if ($urandom_range(4) == 0) begin
        msg_q.push_back(8'($urandom()));
      end
    end else if (pick < 94) begin
      append_frame($urandom_range(4, 1), 1'b1, 1'b1);
    end else begin
      repeat ($urandom_range(6, 1)) msg_q.push_back(8'($urandom()));
    end
  endtask

  task automatic run_traffic(input int target);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      build_message();
      send_message();
    end
  endtask

  initial begin
    in_ch.valid          = 1'b0;
    in_ch.in_byte        = '0;
    in_ch.end_of_message = 1'b0;
    out_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = '0;
    cfg_ch.data          = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed messages with the reset markers
    msg_q = '{8'h00};
    send_message();
    msg_q = '{8'h88, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_message();
    msg_q = '{8'h89, 8'hFE, 8'h00, 8'h01, 8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h3C};
    send_message();
    msg_q = '{8'h01, 8'h7F};
    send_message();
    msg_q = '{8'h0F, 8'h00, 8'hAA};
    send_message();
    msg_q = '{8'h82, 8'hFF, 8'hFF, 8'hFF};
    send_message();
    drain();

    write_reg(CfgMarkerPing, 8'hFF);
    write_reg(CfgMarkerClose, 8'h00);
    write_reg(CfgMarkerStd, 8'hA5);
    write_reg(CfgSpare, 8'h3C);
    run_traffic(10);
    drain();

    send_idle_pct = 78;
    recv_idle_pct = 34;
    write_reg(CfgMarkerPing, 8'($urandom()));
    write_reg(CfgMarkerClose, 8'($urandom()));
    write_reg(CfgMarkerStd, 8'($urandom()));
    run_traffic(10);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CfgMarkerPing, 8'h00);
    write_reg(CfgMarkerClose, 8'hFF);
    write_reg(CfgMarkerStd, 8'hFF);
    hold_req <= ~hold_req;
    run_traffic(10);
    drain();
    run_traffic(5);
    drain();

    $display("covered %0d message bytes, %0d result words and %0d register writes",
             bytes_seen, words_seen, writes_seen);
    $display("under three idle mixes, one long output hold-off and mid-run drains");
    if (mismatches == 0 && words_due == 0) begin
      $display("websocket_frame_unmasker: match");
    end else begin
      $display("websocket_frame_unmasker: mismatch");
    end
    $finish;
  end

endmodule
